// ===== src/lzw_byte_compressor_macros.svh =====
// Assertion helpers for the LZW compressor checker.
`ifndef LZW_BYTE_COMPRESSOR_MACROS_SVH
`define LZW_BYTE_COMPRESSOR_MACROS_SVH

// Clocked property, muted while reset is high.
`define LZWC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that also holds across reset.
`define LZWC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/lzwc_pkg.sv =====
package lzwc_pkg;

  localparam int DICT_ENTRIES_DEF = 4096;
  localparam int CODE_BITS_DEF    = 12;

  localparam int BYTE_W = 8;
  localparam int CFG_W  = 13;

  // Codes below this are implied single-byte codes.
  localparam int SINGLE_CODES = 256;
  // Smallest usable dictionary limit.
  localparam int MIN_LIMIT    = 257;
  localparam int MAX_RESET    = 4096;

  localparam logic [BYTE_W-1:0] BYTE_CODE_FLIP = 8'h80;

endpackage

// ===== src/lzwc_if.sv =====
interface lzwc_data_if;
  import lzwc_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              end_of_stream;

  modport source(output valid, output data_byte, output end_of_stream, input ready);
  modport sink(input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface lzwc_result_if #(
  parameter int CODE_BITS = lzwc_pkg::CODE_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [CODE_BITS-1:0] code;
  logic                 last_code;

  modport source(output valid, output code, output last_code, input ready);
  modport sink(input valid, input code, input last_code, output ready);
endinterface

interface lzwc_cfg_if;
  import lzwc_pkg::*;

  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] max_entries;

  modport source(output valid, output max_entries, input ready);
  modport sink(input valid, input max_entries, output ready);
endinterface

// ===== src/lzw_byte_compressor.sv =====
// LZW byte compressor. Takes one byte per item on the data channel and emits
// dictionary codes on the result channel; an item flagged end_of_stream also
// flushes the pending code with last_code set and restarts the dictionary.
// Single-byte codes are implied as byte XOR 0x80; learned pairs sit at codes
// 256 and up. max_entries (clamped to 257..DICT_ENTRIES) is the size at which
// the dictionary falls back to the 256 single-byte codes, checked as each byte
// is taken. The lookup is one compare unit walking the dictionary memory
// through its single read port, one entry per cycle. A byte that misses is
// accepted, then each learned entry in use is read in turn, the last read is
// seen to come back and the scan drains, the pair is stored (if there is
// room) and the prefix code emitted, and the byte finishes. A hit stops the
// scan early and takes the matched entry's code as the new prefix.
// An end-of-stream byte that misses needs at least one more cycle, since its
// flush waits for the miss code to leave the output register, and result
// stalls stretch any emit further. The first byte of a stream skips the scan.
// A finished code waits in an output register while the next byte is taken.
module lzw_byte_compressor #(
  parameter int DICT_ENTRIES = lzwc_pkg::DICT_ENTRIES_DEF,
  parameter int CODE_BITS    = lzwc_pkg::CODE_BITS_DEF
) (
  input logic          clk,
  input logic          rst,
  lzwc_data_if.sink    data,
  lzwc_result_if.source result,
  lzwc_cfg_if.sink     cfg
);
  import lzwc_pkg::*;

  localparam int ADDR_W = $clog2(DICT_ENTRIES);
  localparam int CNT_W  = ADDR_W + 1;
  localparam int KEY_W  = ADDR_W + BYTE_W;
  localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;
  localparam logic [1:0] ST_EOS  = 2'd3;

  localparam logic [CNT_W-1:0] CNT_SINGLE = CNT_W'(SINGLE_CODES);
  localparam logic [CNT_W-1:0] CNT_TOP    = CNT_W'(DICT_ENTRIES);
  localparam logic [CMP_W-1:0] LIM_MIN    = CMP_W'(MIN_LIMIT);
  localparam logic [CMP_W-1:0] LIM_TOP    = CMP_W'(DICT_ENTRIES);

  logic [1:0]           state;
  logic [CFG_W-1:0]     max_entries;
  logic [CNT_W-1:0]     entry_count;
  logic [ADDR_W-1:0]    prefix;
  logic                 have_prefix;
  logic [BYTE_W-1:0]    cur_byte;
  logic                 eos_flag;
  logic [CNT_W-1:0]     scan_idx;
  logic [ADDR_W-1:0]    scan_tag;
  logic                 scan_pend;
  logic [CODE_BITS-1:0] out_code;
  logic                 out_last;
  logic                 out_valid;

  logic [CMP_W-1:0]  max_ext;
  logic [CMP_W-1:0]  limit;
  logic [CNT_W-1:0]  count_start;
  logic [KEY_W-1:0]  key;
  logic [KEY_W-1:0]  rd_data;
  logic              rd_en;
  logic              wr_en;
  logic              match;
  logic              room;
  logic [ADDR_W-1:0] byte_code;
  logic [ADDR_W-1:0] new_byte_code;

  assign data.ready       = (state == ST_IDLE) && !rst;
  assign cfg.ready        = !rst;
  assign result.valid     = out_valid;
  assign result.code      = out_code;
  assign result.last_code = out_last;

  // Clamp the configured limit to the usable range.
  always_comb begin
    max_ext = CMP_W'(max_entries);
    if (max_ext < LIM_MIN) begin
      limit = LIM_MIN;
    end else if (max_ext > LIM_TOP) begin
      limit = LIM_TOP;
    end else begin
      limit = max_ext;
    end
  end

  assign count_start   = (CMP_W'(entry_count) == limit) ? CNT_SINGLE : entry_count;
  assign key           = {prefix, cur_byte};
  assign match         = scan_pend && (rd_data == key);
  assign room          = (entry_count < CNT_TOP);
  assign byte_code     = ADDR_W'(cur_byte ^ BYTE_CODE_FLIP);
  assign new_byte_code = ADDR_W'(data.data_byte ^ BYTE_CODE_FLIP);
  assign rd_en         = (state == ST_SCAN) && !match && (scan_idx < entry_count);
  assign wr_en         = (state == ST_MISS) && !out_valid && room;

  lzwc_dict #(
    .ENTRIES (DICT_ENTRIES),
    .WORD_W  (KEY_W)
  ) u_dict (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (scan_idx[ADDR_W-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (entry_count[ADDR_W-1:0]),
    .wr_data (key)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      max_entries <= CFG_W'(MAX_RESET);
      entry_count <= CNT_SINGLE;
      prefix      <= '0;
      have_prefix <= 1'b0;
      scan_pend   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg.valid) begin
        max_entries <= cfg.max_entries;
      end
      if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (data.valid) begin
            cur_byte    <= data.data_byte;
            eos_flag    <= data.end_of_stream;
            entry_count <= count_start;
            if (!have_prefix) begin
              prefix      <= new_byte_code;
              have_prefix <= 1'b1;
              state       <= ST_EOS;
            end else begin
              scan_idx  <= CNT_SINGLE;
              scan_pend <= 1'b0;
              state     <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (match) begin
            prefix    <= scan_tag;
            scan_pend <= 1'b0;
            state     <= ST_EOS;
          end else if (scan_idx < entry_count) begin
            scan_tag  <= scan_idx[ADDR_W-1:0];
            scan_idx  <= scan_idx + CNT_W'(1);
            scan_pend <= 1'b1;
          end else if (!scan_pend) begin
            state <= ST_MISS;
          end else begin
            // last read missed; let the scan drain
            scan_pend <= 1'b0;
          end
        end
        ST_MISS: begin
          if (!out_valid) begin
            if (room) begin
              entry_count <= entry_count + CNT_W'(1);
            end
            out_code  <= CODE_BITS'(prefix);
            out_last  <= 1'b0;
            out_valid <= 1'b1;
            prefix    <= byte_code;
            state     <= ST_EOS;
          end
        end
        ST_EOS: begin
          if (!eos_flag) begin
            state <= ST_IDLE;
          end else if (!out_valid) begin
            out_code    <= CODE_BITS'(prefix);
            out_last    <= 1'b1;
            out_valid   <= 1'b1;
            have_prefix <= 1'b0;
            prefix      <= '0;
            entry_count <= CNT_SINGLE;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/lzwc_dict.sv =====
module lzwc_dict #(
  parameter int ENTRIES = lzwc_pkg::DICT_ENTRIES_DEF,
  parameter int WORD_W  = 20
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [$clog2(ENTRIES)-1:0] rd_addr,
  output logic [WORD_W-1:0]          rd_data,
  input  logic                       wr_en,
  input  logic [$clog2(ENTRIES)-1:0] wr_addr,
  input  logic [WORD_W-1:0]          wr_data
);

  logic [WORD_W-1:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/lzwc_checker.sv =====
`include "lzw_byte_compressor_macros.svh"

module lzwc_checker #(
  parameter int CODE_BITS = lzwc_pkg::CODE_BITS_DEF
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 data_valid,
  input logic                 data_ready,
  input logic                 result_valid,
  input logic                 result_ready,
  input logic [CODE_BITS-1:0] result_code,
  input logic                 result_last_code
);

  // The block leaves idle whenever it takes an item, so ready drops after a take.
  `LZWC_ASSERT(a_busy_after_take, (data_valid && data_ready) |=> !data_ready, "ready held after item taken")

  `LZWC_ASSERT_ALWAYS(a_no_result_after_reset, $past(rst) |-> !result_valid, "result valid out of reset")

  `LZWC_ASSERT(a_result_held, (result_valid && !result_ready) |=> result_valid, "result dropped while stalled")

  `LZWC_ASSERT(a_result_stable, (result_valid && !result_ready) |=> ($stable(result_code) && $stable(result_last_code)), "result changed while stalled")

endmodule

bind lzw_byte_compressor lzwc_checker #(
  .CODE_BITS (CODE_BITS)
) u_lzwc_checker (
  .clk              (clk),
  .rst              (rst),
  .data_valid       (data.valid),
  .data_ready       (data.ready),
  .result_valid     (result.valid),
  .result_ready     (result.ready),
  .result_code      (result.code),
  .result_last_code (result.last_code)
);

// ===== tb/tb_lzw_byte_compressor.sv =====
`timescale 1ns / 100ps

module tb_lzw_byte_compressor;
  import lzwc_pkg::*;

  localparam int DICT_ENTRIES   = DICT_ENTRIES_DEF;
  localparam int CODE_BITS      = CODE_BITS_DEF;
  localparam int ITEM_TARGET    = 2000;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int CYCLE_LIMIT    = 20000000;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_stream;
  } byte_item_t;

  typedef struct packed {
    logic [CODE_BITS-1:0] code;
    logic                 last_code;
  } code_item_t;

  typedef enum int {STREAM_NOISE, STREAM_FEW, STREAM_RUN} stream_style_e;
  typedef enum int {READY_ALWAYS, READY_HALF, READY_SPARSE, READY_MASK} ready_style_e;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lzwc_data_if                           data_ch();
  lzwc_result_if #(.CODE_BITS(CODE_BITS)) result_ch();
  lzwc_cfg_if                            cfg_ch();

  lzw_byte_compressor #(
    .DICT_ENTRIES(DICT_ENTRIES),
    .CODE_BITS(CODE_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .data(data_ch),
    .result(result_ch),
    .cfg(cfg_ch)
  );

  // Testbench-side drive registers, known from time zero
  logic              drv_valid = 1'b0;
  logic [BYTE_W-1:0] drv_byte  = '0;
  logic              drv_eos   = 1'b0;
  logic              rcv_ready = 1'b0;
  logic              cfg_valid = 1'b0;
  logic [CFG_W-1:0]  cfg_limit = '0;

  assign data_ch.valid         = drv_valid;
  assign data_ch.data_byte     = drv_byte;
  assign data_ch.end_of_stream = drv_eos;
  assign result_ch.ready       = rcv_ready;
  assign cfg_ch.valid          = cfg_valid;
  assign cfg_ch.max_entries    = cfg_limit;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Compressor state as seen from outside
  logic [CODE_BITS+BYTE_W-1:0] pair_store [DICT_ENTRIES];
  int                          dict_count  = SINGLE_CODES;
  logic [CODE_BITS-1:0]        prefix_q    = '0;
  bit                          prefix_live = 1'b0;
  logic [CFG_W-1:0]            size_limit  = CFG_W'(MAX_RESET);

  byte_item_t byte_queue [$];
  code_item_t codes_due [$];

  logic byte_took = 1'b0;
  int   fail_count      = 0;
  int   bytes_in        = 0;
  int   codes_checked   = 0;
  int   flushes_checked = 0;
  int   limit_writes    = 0;
  int   cycle_count     = 0;

  int holdoff_requests = 0;
  int holdoffs_served  = 0;
  int holdoff_left     = 0;

  function automatic void compress_byte(input logic [BYTE_W-1:0] b, input logic eos);
    logic [CODE_BITS+BYTE_W-1:0] key;
    int lim;
    int hit;
    lim = size_limit;
    if (lim < MIN_LIMIT) lim = MIN_LIMIT;
    if (lim > DICT_ENTRIES) lim = DICT_ENTRIES;
    // Fall back to the single-byte codes; the pending prefix survives
    if (dict_count == lim) dict_count = SINGLE_CODES;
    if (!prefix_live) begin
      prefix_q    = CODE_BITS'(b ^ BYTE_CODE_FLIP);
      prefix_live = 1'b1;
    end else begin
      key = {prefix_q, b};
      hit = -1;
      for (int i = SINGLE_CODES; i < dict_count && i < DICT_ENTRIES; i++) begin
        if (hit < 0 && pair_store[i] == key) hit = i;
      end
      if (hit >= 0) begin
        prefix_q = CODE_BITS'(hit);
      end else begin
        if (dict_count < DICT_ENTRIES) begin
          pair_store[dict_count] = key;
          dict_count++;
        end
        codes_due.insert(codes_due.size(), code_item_t'{code: prefix_q, last_code: 1'b0});
        prefix_q = CODE_BITS'(b ^ BYTE_CODE_FLIP);
      end
    end
    if (eos) begin
      codes_due.insert(codes_due.size(), code_item_t'{code: prefix_q, last_code: 1'b1});
      prefix_live = 1'b0;
      prefix_q    = '0;
      dict_count  = SINGLE_CODES;
    end
  endfunction

  // Sample handshakes at the rising edge: config, codes out, bytes in
  always @(posedge clk) begin : edge_monitor
    code_item_t want;
    if (rst) begin
      byte_took <= 1'b0;
    end else begin
      byte_took <= drv_valid && data_ch.ready;
      if (cfg_ch.valid && cfg_ch.ready) size_limit = cfg_ch.max_entries;
      if (result_ch.valid && result_ch.ready) begin
        if (codes_due.size() == 0) begin
          $error("unexpected code %0d with last_code %0b", result_ch.code,
                 result_ch.last_code);
          fail_count++;
        end else begin
          want = codes_due.pop_front();
          if (result_ch.code !== want.code) begin
            $error("code: expected %0d, got %0d", want.code, result_ch.code);
            fail_count++;
          end
          if (result_ch.last_code !== want.last_code) begin
            $error("last_code: expected %0b, got %0b", want.last_code,
                   result_ch.last_code);
            fail_count++;
          end
          codes_checked++;
          if (want.last_code) flushes_checked++;
        end
      end
      if (data_ch.valid && data_ch.ready) begin
        compress_byte(data_ch.data_byte, data_ch.end_of_stream);
        bytes_in++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Byte sender: bursts of random length separated by random gaps
  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk) begin : byte_driver
    byte_item_t nxt;
    if (rst) begin
      drv_valid <= 1'b0;
    end else if (drv_valid && !byte_took) begin
      // hold the offered item until taken
    end else if (gap_left > 0) begin
      gap_left  <= gap_left - 1;
      drv_valid <= 1'b0;
    end else if (byte_queue.size() > 0) begin
      nxt = byte_queue.pop_front();
      drv_byte  <= nxt.data_byte;
      drv_eos   <= nxt.end_of_stream;
      drv_valid <= 1'b1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 24);
        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      drv_valid <= 1'b0;
    end
  end

  // Code receiver: stall style changes every so often; long hold-offs on request
  ready_style_e ready_style = READY_ALWAYS;
  int           style_left  = 0;
  logic [7:0]   stall_mask  = 8'h5b;

  always @(negedge clk) begin : code_receiver
    if (rst) begin
      rcv_ready <= 1'b0;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
      rcv_ready    <= 1'b0;
    end else if (holdoffs_served != holdoff_requests) begin
      holdoffs_served <= holdoffs_served + 1;
      holdoff_left    <= HOLDOFF_CYCLES;
      rcv_ready       <= 1'b0;
    end else begin
      if (style_left == 0) begin
        ready_style <= ready_style_e'($urandom_range(0, 3));
        style_left  <= $urandom_range(40, 250);
        stall_mask  <= 8'($urandom) | 8'h01;
      end else begin
        style_left <= style_left - 1;
      end
      case (ready_style)
        READY_ALWAYS: rcv_ready <= 1'b1;
        READY_HALF:   rcv_ready <= 1'($urandom_range(0, 1));
        READY_SPARSE: rcv_ready <= ($urandom_range(0, 3) == 0);
        default:      rcv_ready <= stall_mask[cycle_count[2:0]];
      endcase
    end
  end

  task automatic push_byte(input logic [BYTE_W-1:0] b, input logic eos);
    byte_queue.insert(byte_queue.size(), byte_item_t'{data_byte: b, end_of_stream: eos});
  endtask

  // Wait until every byte is taken and every code is back, then let the
  // block finish any scan that produces no code
  task automatic settle();
    do @(posedge clk);
    while (byte_queue.size() != 0 || drv_valid || codes_due.size() != 0);
    repeat (dict_count - SINGLE_CODES + 12) @(negedge clk);
  endtask

  task automatic write_limit(input logic [CFG_W-1:0] value);
    settle();
    cfg_limit <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ch.ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    limit_writes++;
  endtask

  task automatic queue_stream(input int len, input stream_style_e style, input bit close);
    logic [BYTE_W-1:0] letters [4];
    logic [BYTE_W-1:0] b;
    int span;
    foreach (letters[k]) letters[k] = 8'($urandom);
    span = $urandom_range(1, 3);
    for (int n = 0; n < len; n++) begin
      case (style)
        STREAM_NOISE: b = 8'($urandom);
        STREAM_FEW:   b = letters[$urandom_range(0, span)];
        default:      b = letters[0];
      endcase
      push_byte(b, close && (n == len - 1));
    end
  endtask

  logic [CFG_W-1:0] corner_limits [5] = '{CFG_W'(MIN_LIMIT), CFG_W'(MAX_RESET), 13'd260,
                                          13'd0, 13'h1fff};

  initial begin : stimulus
    int               phase;
    int               random_items;
    int               open_streams;
    int               len;
    int               r;
    logic [CFG_W-1:0] lim;
    stream_style_e    style;
    bit               close;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Lone byte closing its own stream
    push_byte(8'h00, 1'b1);
    // Repeated byte: pairs hit and the prefix grows
    push_byte(8'hff, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'hff, 1'b1);
    // Bytes mapping to codes 0 and 255
    push_byte(8'h80, 1'b0);
    push_byte(8'h7f, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h7f, 1'b0);
    push_byte(8'h80, 1'b1);
    // Leave a stream open across a limit below range: table is full next byte
    push_byte(8'h55, 1'b0);
    push_byte(8'haa, 1'b0);
    write_limit('0);
    push_byte(8'h55, 1'b0);
    push_byte(8'haa, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'haa, 1'b1);
    // Limit above range clamps to the full dictionary
    write_limit(13'h1fff);
    push_byte(8'h01, 1'b0);
    push_byte(8'h02, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h02, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h02, 1'b1);

    phase        = 0;
    random_items = 0;
    open_streams = 0;
    while (random_items < ITEM_TARGET) begin
      if (phase < 5) begin
        lim = corner_limits[phase];
      end else begin
        case ($urandom_range(0, 9))
          0:       lim = '0;
          1:       lim = CFG_W'(MIN_LIMIT);
          2:       lim = CFG_W'(MAX_RESET);
          3:       lim = 13'h1fff;
          4:       lim = CFG_W'($urandom_range(0, MIN_LIMIT - 1));
          5:       lim = CFG_W'($urandom_range(MAX_RESET + 1, 8191));
          default: lim = CFG_W'($urandom_range(MIN_LIMIT + 1, 700));
        endcase
      end
      write_limit(lim);

      // Stall the receiver long enough to back up the input
      if (phase % 7 == 3) begin
        holdoff_requests++;
        queue_stream(60, STREAM_FEW, 1'b1);
        random_items += 60;
        open_streams = 0;
      end

      repeat ($urandom_range(1, 4)) begin
        r = $urandom_range(0, 99);
        if (r < 80) len = $urandom_range(1, 30);
        else if (r < 95) len = $urandom_range(31, 120);
        else len = $urandom_range(121, 300);
        r = $urandom_range(0, 9);
        style = (r < 4) ? STREAM_NOISE : (r < 8) ? STREAM_FEW : STREAM_RUN;
        // Mostly close streams; an open one carries over into the next setting
        close = (open_streams >= 2) || ($urandom_range(0, 6) != 0);
        open_streams = close ? 0 : open_streams + 1;
        queue_stream(len, style, close);
        random_items += len;
      end
      phase++;
    end

    queue_stream($urandom_range(1, 10), STREAM_FEW, 1'b1);
    settle();

    $display("Run covered %0d bytes in, %0d codes checked, %0d end-of-stream flushes",
             bytes_in, codes_checked, flushes_checked);
    $display("Across %0d dictionary limit writes and %0d long receiver hold-offs",
             limit_writes, holdoffs_served);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
